>>> hdl/typed_value_scan_compare_core_defines.svh
// Assertion macros for the typed value scan compare core.
// Included by the top level; no other dependencies.
`ifndef TYPED_VALUE_SCAN_COMPARE_CORE_DEFINES_SVH
`define TYPED_VALUE_SCAN_COMPARE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TVSC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TVSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TVSC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TVSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/tvsc_pkg.sv
// Shared types, codes and IEEE double helpers for the scan compare core.
// No dependencies.
package tvsc_pkg;

   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_ELEMENT_TYPE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SCAN_KIND     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_UPPER_BOUND   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_UPPER_PRESENT = 3'd4;

   localparam logic [3:0] TYPE_INT8   = 4'd0;
   localparam logic [3:0] TYPE_INT16  = 4'd1;
   localparam logic [3:0] TYPE_INT32  = 4'd2;
   localparam logic [3:0] TYPE_INT64  = 4'd3;
   localparam logic [3:0] TYPE_UINT8  = 4'd4;
   localparam logic [3:0] TYPE_UINT16 = 4'd5;
   localparam logic [3:0] TYPE_UINT32 = 4'd6;
   localparam logic [3:0] TYPE_UINT64 = 4'd7;
   localparam logic [3:0] TYPE_FLOAT  = 4'd8;
   localparam logic [3:0] TYPE_DOUBLE = 4'd9;
   localparam logic [3:0] TYPE_BOOL   = 4'd10;
   localparam logic [3:0] TYPE_OTHER  = 4'd11;

   localparam logic [3:0] KIND_EXACT     = 4'd0;
   localparam logic [3:0] KIND_BIGGER    = 4'd1;
   localparam logic [3:0] KIND_SMALLER   = 4'd2;
   localparam logic [3:0] KIND_BETWEEN   = 4'd3;
   localparam logic [3:0] KIND_CHANGED   = 4'd4;
   localparam logic [3:0] KIND_UNCHANGED = 4'd5;
   localparam logic [3:0] KIND_INCREASED = 4'd6;
   localparam logic [3:0] KIND_DECREASED = 4'd7;
   localparam logic [3:0] KIND_SUBSTRING = 4'd8;

   localparam logic [3:0] RESET_ELEMENT_TYPE = 4'd2;

   localparam logic [63:0] DOUBLE_QNAN = 64'h7FF8_0000_0000_0000;

   typedef struct packed {
      logic [3:0]  element_type;
      logic [3:0]  scan_kind;
      logic [63:0] tolerance_bits;
      logic [63:0] upper_bound;
      logic        upper_bound_present;
   } cfg_type;

   function automatic logic fp_is_nan(input logic [63:0] a);
      return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
   endfunction

   function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
      logic r;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         r = 1'b0;
      end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
         r = 1'b0;
      end else if (a[63] != b[63]) begin
         r = a[63];
      end else if (!a[63]) begin
         r = a[62:0] < b[62:0];
      end else begin
         r = a[62:0] > b[62:0];
      end
      return r;
   endfunction

   function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
      logic r;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         r = 1'b0;
      end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
         r = 1'b1;
      end else begin
         r = fp_lt(a, b) || (a == b);
      end
      return r;
   endfunction

   // Exact widening of a single to a double, subnormals normalized.
   function automatic logic [63:0] float_to_double(input logic [31:0] w);
      logic [4:0]  p;
      logic [22:0] f;
      logic [22:0] fs;
      logic [10:0] e;
      logic [63:0] r;
      f = w[22:0];
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (f[i]) p = 5'(i);
      end
      if (w[30:23] == 8'hFF) begin
         r = {w[31], 11'h7FF, f, 29'd0};
      end else if (w[30:23] == 8'd0 && f == 23'd0) begin
         r = {w[31], 63'd0};
      end else if (w[30:23] == 8'd0) begin
         fs = f << (5'd23 - p);
         e  = 11'd874 + 11'(p);
         r  = {w[31], e, fs, 29'd0};
      end else begin
         e = 11'(w[30:23]) + 11'd896;
         r = {w[31], e, f, 29'd0};
      end
      return r;
   endfunction

   function automatic logic [5:0] lead_zeros56(input logic [55:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 56; i++) begin
         if (v[i]) n = 6'(55 - i);
      end
      return n;
   endfunction

endpackage

>>> hdl/tvsc_csr.sv
// APB-style configuration registers of the scan compare core.
// Depends on tvsc_pkg.
module tvsc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tvsc_pkg::ADDR_W-1:0] paddr,
   input  logic [tvsc_pkg::DATA_W-1:0] pwdata,
   output logic [tvsc_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output tvsc_pkg::cfg_type           cfg
);
   import tvsc_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  idx;
   logic                  wr;

   assign idx    = paddr[ADDR_W-1:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_ELEMENT_TYPE:  cfg_in.element_type = pwdata[3:0];
            REG_SCAN_KIND:     cfg_in.scan_kind = pwdata[3:0];
            REG_TOLERANCE:     cfg_in.tolerance_bits = pwdata;
            REG_UPPER_BOUND:   cfg_in.upper_bound = pwdata;
            REG_UPPER_PRESENT: cfg_in.upper_bound_present = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ELEMENT_TYPE:  prdata = {60'd0, cfg_ff.element_type};
         REG_SCAN_KIND:     prdata = {60'd0, cfg_ff.scan_kind};
         REG_TOLERANCE:     prdata = cfg_ff.tolerance_bits;
         REG_UPPER_BOUND:   prdata = cfg_ff.upper_bound;
         REG_UPPER_PRESENT: prdata = {63'd0, cfg_ff.upper_bound_present};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{element_type: RESET_ELEMENT_TYPE, scan_kind: KIND_EXACT,
                     tolerance_bits: 64'd0, upper_bound: 64'd0,
                     upper_bound_present: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/tvsc_fp_add.sv
// Four-stage IEEE double adder, round to nearest even.
// Depends on tvsc_pkg; advances only while en is high.
module tvsc_fp_add (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] sum
);
   import tvsc_pkg::*;

   typedef struct packed {
      logic        sign;
      logic        zsign;
      logic        eff_sub;
      logic        special;
      logic [63:0] sval;
      logic [10:0] exp;
      logic [55:0] mbig;
      logic [55:0] msmall;
   } align_type;

   typedef struct packed {
      logic        sign;
      logic        zsign;
      logic        special;
      logic [63:0] sval;
      logic [10:0] exp;
      logic [56:0] sum;
   } add_type;

   typedef struct packed {
      logic        sign;
      logic        zsign;
      logic        special;
      logic        zero;
      logic [63:0] sval;
      logic [11:0] exp;
      logic [55:0] mant;
   } norm_type;

   align_type al_ff, al_in;
   add_type   ad_ff, ad_in;
   norm_type  nm_ff, nm_in;
   logic [63:0] res_ff, res_in;

   // Align: order by magnitude, shift the smaller operand with sticky.
   always_comb begin
      logic [63:0] big, sml;
      logic [10:0] eb, es, d;
      logic [55:0] mb, ms, mask;
      logic [5:0]  sh;
      logic        a_nan, b_nan, a_inf, b_inf;
      a_nan = fp_is_nan(a);
      b_nan = fp_is_nan(b);
      a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
      b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
      if (b[62:0] > a[62:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      eb = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
      es = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
      mb = {big[62:52] != 11'd0, big[51:0], 3'b000};
      ms = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
      d  = eb - es;
      sh = (d > 11'd63) ? 6'd63 : d[5:0];
      mask = ~({56{1'b1}} << sh);
      al_in.sign    = big[63];
      al_in.eff_sub = a[63] ^ b[63];
      al_in.zsign   = (a[63] ^ b[63]) ? 1'b0 : a[63];
      al_in.exp     = eb;
      al_in.mbig    = mb;
      al_in.msmall  = (ms >> sh) | {55'd0, |(ms & mask)};
      al_in.special = a_nan || b_nan || a_inf || b_inf;
      if (a_nan || b_nan || (a_inf && b_inf && (a[63] != b[63]))) begin
         al_in.sval = DOUBLE_QNAN;
      end else if (a_inf) begin
         al_in.sval = a;
      end else begin
         al_in.sval = b;
      end
   end

   always_comb begin
      ad_in.sign    = al_ff.sign;
      ad_in.zsign   = al_ff.zsign;
      ad_in.special = al_ff.special;
      ad_in.sval    = al_ff.sval;
      ad_in.exp     = al_ff.exp;
      ad_in.sum     = al_ff.eff_sub ? ({1'b0, al_ff.mbig} - {1'b0, al_ff.msmall})
                                    : ({1'b0, al_ff.mbig} + {1'b0, al_ff.msmall});
   end

   // Normalize: right by one on carry, else left but not below the subnormal exponent.
   always_comb begin
      logic [5:0]  lz;
      logic [10:0] lim;
      logic [5:0]  s;
      nm_in.sign    = ad_ff.sign;
      nm_in.zsign   = ad_ff.zsign;
      nm_in.special = ad_ff.special;
      nm_in.sval    = ad_ff.sval;
      nm_in.zero    = (ad_ff.sum == 57'd0);
      lz  = lead_zeros56(ad_ff.sum[55:0]);
      lim = ad_ff.exp - 11'd1;
      s   = (11'(lz) > lim) ? lim[5:0] : lz;
      if (ad_ff.sum[56]) begin
         nm_in.mant = {ad_ff.sum[56:2], ad_ff.sum[1] | ad_ff.sum[0]};
         nm_in.exp  = {1'b0, ad_ff.exp} + 12'd1;
      end else begin
         nm_in.mant = ad_ff.sum[55:0] << s;
         nm_in.exp  = {1'b0, ad_ff.exp} - 12'(s);
      end
   end

   // Round and pack; a carry out of the fraction bumps the exponent.
   always_comb begin
      logic [10:0] field;
      logic        inc;
      logic [62:0] body;
      field = nm_ff.mant[55] ? nm_ff.exp[10:0] : 11'd0;
      inc   = nm_ff.mant[2] & (nm_ff.mant[1] | nm_ff.mant[0] | nm_ff.mant[3]);
      body  = {field, nm_ff.mant[54:3]} + {62'd0, inc};
      if (nm_ff.special) begin
         res_in = nm_ff.sval;
      end else if (nm_ff.zero) begin
         res_in = {nm_ff.zsign, 63'd0};
      end else if (nm_ff.exp >= 12'd2047) begin
         res_in = {nm_ff.sign, 11'h7FF, 52'd0};
      end else begin
         res_in = {nm_ff.sign, body};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         al_ff  <= al_in;
         ad_ff  <= ad_in;
         nm_ff  <= nm_in;
         res_ff <= res_in;
      end
   end

   assign sum = res_ff;

endmodule

>>> hdl/typed_value_scan_compare_core.sv
// Channel  | valid/ready       | payload
// req      | req_valid/ready   | current_value, current_present, reference_value,
//          |                   | reference_present
// rsp      | rsp_valid/ready   | match
// csr      | psel/penable      | paddr, pwdata, prdata (64-bit, register i at 8*i)
//
// One item per cycle while the output is not stalled; the stages from acceptance to rsp_valid are:
// decode, four stages of the shared-shape double adders, compare into the output register.
// All stages move together; a stalled result holds the whole pipe, and req_ready
// stays high while the output register is empty or being taken.
// Synchronous active-high reset clears valid bits and configuration.
// Depends on tvsc_pkg, tvsc_csr, tvsc_fp_add and the defines header.
`include "typed_value_scan_compare_core_defines.svh"
module typed_value_scan_compare_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [63:0]                 req_current_value,
   input  logic                        req_current_present,
   input  logic [63:0]                 req_reference_value,
   input  logic                        req_reference_present,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_match,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tvsc_pkg::ADDR_W-1:0] paddr,
   input  logic [tvsc_pkg::DATA_W-1:0] pwdata,
   output logic [tvsc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import tvsc_pkg::*;

   localparam int DLY = 4;

   typedef struct packed {
      logic        valid;
      logic        kill;
      logic        is_real;
      logic [3:0]  kind;
      logic [63:0] cur;
      logic [63:0] refv;
      logic [63:0] ub;
      logic [63:0] tol;
      logic [63:0] ck;
      logic [63:0] ak;
      logic [63:0] bk;
   } stage_type;

   cfg_type     cfg;
   logic        en;
   stage_type   s0_ff, s0_in;
   stage_type   dl_ff [DLY];
   logic [63:0] a_plus, a_minus, b_plus, diff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_match_ff, rsp_match_in;

   tvsc_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   function automatic logic [63:0] int_key(input logic [3:0] t, input logic [63:0] r);
      logic [63:0] v;
      case (t)
         TYPE_INT8:   v = {{56{r[7]}}, r[7:0]} ^ {1'b1, 63'd0};
         TYPE_INT16:  v = {{48{r[15]}}, r[15:0]} ^ {1'b1, 63'd0};
         TYPE_INT32:  v = {{32{r[31]}}, r[31:0]} ^ {1'b1, 63'd0};
         TYPE_INT64:  v = r ^ {1'b1, 63'd0};
         TYPE_UINT8:  v = {56'd0, r[7:0]};
         TYPE_UINT16: v = {48'd0, r[15:0]};
         TYPE_UINT32: v = {32'd0, r[31:0]};
         TYPE_UINT64: v = r;
         default:     v = {63'd0, r[7:0] != 8'd0};
      endcase
      return v;
   endfunction

   // Decode: widen reals, clamp tolerance, build ordered integer keys.
   always_comb begin
      logic dbl;
      dbl = (cfg.element_type == TYPE_DOUBLE);
      s0_in.valid   = req_valid;
      s0_in.kill    = !req_current_present || !req_reference_present
                      || (cfg.scan_kind == KIND_BETWEEN && !cfg.upper_bound_present)
                      || (cfg.scan_kind > KIND_DECREASED)
                      || (cfg.element_type > TYPE_BOOL);
      s0_in.is_real = (cfg.element_type == TYPE_FLOAT) || dbl;
      s0_in.kind    = cfg.scan_kind;
      s0_in.cur     = dbl ? req_current_value : float_to_double(req_current_value[31:0]);
      s0_in.refv    = dbl ? req_reference_value
                          : float_to_double(req_reference_value[31:0]);
      s0_in.ub      = dbl ? cfg.upper_bound : float_to_double(cfg.upper_bound[31:0]);
      s0_in.tol     = (cfg.tolerance_bits[63] && !fp_is_nan(cfg.tolerance_bits))
                      ? 64'd0 : cfg.tolerance_bits;
      s0_in.ck      = int_key(cfg.element_type, req_current_value);
      s0_in.ak      = int_key(cfg.element_type, req_reference_value);
      s0_in.bk      = int_key(cfg.element_type, cfg.upper_bound);
   end

   tvsc_fp_add u_add_ap (.clock(clock), .en(en), .a(s0_ff.refv), .b(s0_ff.tol),
                         .sum(a_plus));
   tvsc_fp_add u_add_am (.clock(clock), .en(en), .a(s0_ff.refv),
                         .b({~s0_ff.tol[63], s0_ff.tol[62:0]}), .sum(a_minus));
   tvsc_fp_add u_add_bp (.clock(clock), .en(en), .a(s0_ff.ub), .b(s0_ff.tol),
                         .sum(b_plus));
   tvsc_fp_add u_add_df (.clock(clock), .en(en), .a(s0_ff.cur),
                         .b({~s0_ff.refv[63], s0_ff.refv[62:0]}), .sum(diff));

   // Final compare, aligned with the adder outputs.
   always_comb begin
      stage_type   l;
      logic [63:0] mag_d;
      logic        m;
      l     = dl_ff[DLY-1];
      mag_d = {1'b0, diff[62:0]};
      m     = 1'b0;
      if (l.is_real) begin
         case (l.kind)
            KIND_EXACT, KIND_UNCHANGED:  m = fp_le(mag_d, l.tol);
            KIND_BIGGER, KIND_INCREASED: m = fp_lt(a_plus, l.cur);
            KIND_SMALLER, KIND_DECREASED: m = fp_lt(l.cur, a_minus);
            KIND_BETWEEN:  m = fp_le(a_minus, l.cur) && fp_le(l.cur, b_plus);
            KIND_CHANGED:  m = fp_lt(l.tol, mag_d);
            default:       m = 1'b0;
         endcase
      end else begin
         case (l.kind)
            KIND_EXACT, KIND_UNCHANGED:  m = (l.ck == l.ak);
            KIND_BIGGER, KIND_INCREASED: m = (l.ck > l.ak);
            KIND_SMALLER, KIND_DECREASED: m = (l.ck < l.ak);
            KIND_BETWEEN:  m = (l.ck >= l.ak) && (l.ck <= l.bk);
            KIND_CHANGED:  m = (l.ck != l.ak);
            default:       m = 1'b0;
         endcase
      end
      rsp_match_in = m && !l.kill;
      rsp_valid_in = l.valid;
   end

   // Advance the whole pipe together; hold on stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DLY; i++) dl_ff[i].valid <= 1'b0;
      end else if (en) begin
         s0_ff        <= s0_in;
         dl_ff[0]     <= s0_ff;
         for (int i = 1; i < DLY; i++) dl_ff[i] <= dl_ff[i-1];
         rsp_valid_ff <= rsp_valid_in;
         rsp_match_ff <= rsp_match_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;

   `TVSC_ASSERT_NEXT(a_absent_kills, clock, reset, req_valid && req_ready && !req_current_present, s0_ff.valid && s0_ff.kill)
   `TVSC_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(dl_ff[DLY-1].valid) && $stable(s0_ff.valid))
   `TVSC_ASSERT_SAME(a_rise_from_pipe, clock, reset, $rose(rsp_valid_ff), $past(dl_ff[DLY-1].valid))

endmodule
